// ----- rtl/core/srp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCKS5 request parser package
// Shared types and constants for the front classifier, the op queue and the
// back executor.
// ----------------------------------------------------------------------------
package srp_pkg;

  // Parser phase, tracked by the front.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IPV4,
    PH_IPV6,
    PH_DLEN,
    PH_DNAME,
    PH_PORT,
    PH_DONE
  } phase_t;

  // What the back does with one beat's byte.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_VERSION,
    OP_COMMAND,
    OP_TYPE,
    OP_ADDR_HI,
    OP_ADDR_LO,
    OP_DLEN,
    OP_DNAME,
    OP_PORT
  } op_kind_t;

  localparam logic [1:0] ST_MORE     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;

  localparam logic [7:0] TYPE_IPV4   = 8'h01;
  localparam logic [7:0] TYPE_DOMAIN = 8'h03;
  localparam logic [7:0] TYPE_IPV6   = 8'h04;

  // One classified beat travelling from front to back.
  typedef struct packed {
    logic       clear;
    op_kind_t   kind;
    logic [1:0] status;
    logic [7:0] data;
    logic [7:0] dindex;
  } srp_op_t;

endpackage

// ----- rtl/core/srp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCKS5 request parser front
// Tracks the request phase and byte counters and turns each accepted beat
// into an operation and a status for the back.
// ----------------------------------------------------------------------------
module srp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      data_byte,
  input  logic            restart,
  input  logic            q_full,
  output logic            in_stall,
  output logic            push,
  output srp_pkg::srp_op_t push_op
);
  import srp_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] header_count, header_count_next;
  logic [3:0] addr_count, addr_count_next;
  logic [7:0] name_length, name_length_next;
  logic [7:0] name_count, name_count_next;
  logic       port_count, port_count_next;
  logic [1:0] final_status, final_status_next;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    phase_t     ph;
    logic [1:0] hc;
    logic [3:0] ac;
    logic [7:0] nl;
    logic [7:0] nc;
    logic       pc;
    logic [1:0] fs;

    // A restart beat sees the parser as just reset.
    ph = restart ? PH_HEADER : phase;
    hc = restart ? 2'd0 : header_count;
    ac = restart ? 4'd0 : addr_count;
    nl = restart ? 8'd0 : name_length;
    nc = restart ? 8'd0 : name_count;
    pc = restart ? 1'b0 : port_count;
    fs = restart ? ST_MORE : final_status;

    phase_next        = ph;
    header_count_next = hc;
    addr_count_next   = ac;
    name_length_next  = nl;
    name_count_next   = nc;
    port_count_next   = pc;
    final_status_next = fs;

    push_op.clear  = restart;
    push_op.kind   = OP_NONE;
    push_op.status = ST_MORE;
    push_op.data   = data_byte;
    push_op.dindex = 8'd0;

    case (ph)
      PH_DONE: begin
        push_op.status = fs;
      end
      PH_HEADER: begin
        header_count_next = hc + 2'd1;
        case (hc)
          2'd0: push_op.kind = OP_VERSION;
          2'd1: push_op.kind = OP_COMMAND;
          2'd2: push_op.kind = OP_NONE;
          default: begin
            push_op.kind    = OP_TYPE;
            addr_count_next = 4'd0;
            if (data_byte == TYPE_IPV4) begin
              phase_next = PH_IPV4;
            end else if (data_byte == TYPE_IPV6) begin
              phase_next = PH_IPV6;
            end else if (data_byte == TYPE_DOMAIN) begin
              phase_next = PH_DLEN;
            end else begin
              phase_next        = PH_DONE;
              final_status_next = ST_REJECT;
              push_op.status    = ST_REJECT;
            end
          end
        endcase
      end
      PH_IPV4, PH_IPV6: begin
        // IPv6 bytes 0..7 go to the high word, everything else to the low one.
        push_op.kind    = (ph == PH_IPV6 && !ac[3]) ? OP_ADDR_HI : OP_ADDR_LO;
        addr_count_next = ac + 4'd1;
        if ((ph == PH_IPV4 && ac == 4'd3) || (ph == PH_IPV6 && ac == 4'd15)) begin
          phase_next      = PH_PORT;
          port_count_next = 1'b0;
        end
      end
      PH_DLEN: begin
        push_op.kind     = OP_DLEN;
        name_length_next = data_byte;
        name_count_next  = 8'd0;
        if (data_byte == 8'd0) begin
          phase_next      = PH_PORT;
          port_count_next = 1'b0;
        end else begin
          phase_next = PH_DNAME;
        end
      end
      PH_DNAME: begin
        push_op.kind    = OP_DNAME;
        push_op.dindex  = nc;
        name_count_next = nc + 8'd1;
        if (nc + 8'd1 == nl) begin
          phase_next      = PH_PORT;
          port_count_next = 1'b0;
        end
      end
      PH_PORT: begin
        push_op.kind    = OP_PORT;
        port_count_next = 1'b1;
        if (pc) begin
          phase_next        = PH_DONE;
          final_status_next = ST_COMPLETE;
          push_op.status    = ST_COMPLETE;
        end
      end
      default: begin
        push_op.status = fs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 2'd0;
      addr_count   <= 4'd0;
      name_length  <= 8'd0;
      name_count   <= 8'd0;
      port_count   <= 1'b0;
      final_status <= ST_MORE;
    end else if (push) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      addr_count   <= addr_count_next;
      name_length  <= name_length_next;
      name_count   <= name_count_next;
      port_count   <= port_count_next;
      final_status <= final_status_next;
    end
  end

endmodule

// ----- rtl/core/srp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCKS5 request parser op queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module srp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srp_pkg::srp_op_t push_op,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output srp_pkg::srp_op_t q_op
);
  import srp_pkg::*;

  srp_op_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/srp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCKS5 request parser back
// Applies classified beats to the request fields and holds the result beat
// in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module srp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  srp_pkg::srp_op_t q_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [7:0]       version,
  output logic [7:0]       command,
  output logic [7:0]       addr_type,
  output logic [31:0]      ipv4_addr,
  output logic [63:0]      ipv6_high,
  output logic [63:0]      ipv6_low,
  output logic [15:0]      dest_port,
  output logic [7:0]       domain_length,
  output logic             domain_byte_valid,
  output logic [7:0]       domain_byte,
  output logic [7:0]       domain_index
);
  import srp_pkg::*;

  logic [7:0]  version_reg, version_reg_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [63:0] addr_hi, addr_hi_next;
  logic [63:0] addr_lo, addr_lo_next;
  logic [7:0]  name_length, name_length_next;
  logic [15:0] port_shift, port_shift_next;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    version_reg_next = q_op.clear ? 8'd0  : version_reg;
    command_reg_next = q_op.clear ? 8'd0  : command_reg;
    type_reg_next    = q_op.clear ? 8'd0  : type_reg;
    addr_hi_next     = q_op.clear ? 64'd0 : addr_hi;
    addr_lo_next     = q_op.clear ? 64'd0 : addr_lo;
    name_length_next = q_op.clear ? 8'd0  : name_length;
    port_shift_next  = q_op.clear ? 16'd0 : port_shift;
    case (q_op.kind)
      OP_VERSION: version_reg_next = q_op.data;
      OP_COMMAND: command_reg_next = q_op.data;
      OP_TYPE:    type_reg_next    = q_op.data;
      OP_ADDR_HI: addr_hi_next     = {addr_hi_next[55:0], q_op.data};
      OP_ADDR_LO: addr_lo_next     = {addr_lo_next[55:0], q_op.data};
      OP_DLEN:    name_length_next = q_op.data;
      OP_PORT:    port_shift_next  = {port_shift_next[7:0], q_op.data};
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version_reg <= 8'd0;
      command_reg <= 8'd0;
      type_reg    <= 8'd0;
      addr_hi     <= 64'd0;
      addr_lo     <= 64'd0;
      name_length <= 8'd0;
      port_shift  <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        version_reg <= version_reg_next;
        command_reg <= command_reg_next;
        type_reg    <= type_reg_next;
        addr_hi     <= addr_hi_next;
        addr_lo     <= addr_lo_next;
        name_length <= name_length_next;
        port_shift  <= port_shift_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result beat; address words show only for their own address type.
  always_ff @(posedge clk) begin
    if (pop) begin
      status            <= q_op.status;
      version           <= version_reg_next;
      command           <= command_reg_next;
      addr_type         <= type_reg_next;
      ipv4_addr         <= (type_reg_next == TYPE_IPV4) ? addr_lo_next[31:0] : 32'd0;
      ipv6_high         <= (type_reg_next == TYPE_IPV6) ? addr_hi_next : 64'd0;
      ipv6_low          <= (type_reg_next == TYPE_IPV6) ? addr_lo_next : 64'd0;
      dest_port         <= port_shift_next;
      domain_length     <= name_length_next;
      domain_byte_valid <= (q_op.kind == OP_DNAME);
      domain_byte       <= (q_op.kind == OP_DNAME) ? q_op.data : 8'd0;
      domain_index      <= (q_op.kind == OP_DNAME) ? q_op.dindex : 8'd0;
    end
  end

endmodule

// ----- rtl/core/socks5_request_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCKS5 request parser core
// Parses a SOCKS5 request one byte per beat and reports status and the
// decoded fields with every byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one request byte per beat
//   in data_byte. Setting restart on a beat clears the parser and takes that
//   byte as the first byte of a new request.
//   The output channel (out_valid / out_stall) returns exactly one result
//   beat per input beat, in order: status, the header bytes, the address and
//   port assembled so far, and the current domain character with its index.
//   An accepted input beat is first written into a queue entry, and out_valid
//   rises when the back moves it into the result register. Throughput is one
//   beat per cycle while out_stall is low; the front updates its phase and
//   counters for each accepted beat and the back applies one shift per pop.
//   A two-entry queue sits between the front and the back. When out_stall is
//   held, the result register keeps its beat, the queue fills, and in_stall
//   rises once both queue entries are taken.
//   Reset (rst, synchronous) empties the queue, drops out_valid and returns
//   the parser to the start of a request with all fields zero.
// ----------------------------------------------------------------------------
module socks5_request_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  version,
  output logic [7:0]  command,
  output logic [7:0]  addr_type,
  output logic [31:0] ipv4_addr,
  output logic [63:0] ipv6_high,
  output logic [63:0] ipv6_low,
  output logic [15:0] dest_port,
  output logic [7:0]  domain_length,
  output logic        domain_byte_valid,
  output logic [7:0]  domain_byte,
  output logic [7:0]  domain_index
);
  import srp_pkg::*;

  logic    push;
  srp_op_t push_op;
  logic    q_full;
  logic    q_valid;
  srp_op_t q_op;
  logic    pop;

  srp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .data_byte (data_byte),
    .restart   (restart),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_op   (push_op)
  );

  srp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  srp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_op              (q_op),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .version           (version),
    .command           (command),
    .addr_type         (addr_type),
    .ipv4_addr         (ipv4_addr),
    .ipv6_high         (ipv6_high),
    .ipv6_low          (ipv6_low),
    .dest_port         (dest_port),
    .domain_length     (domain_length),
    .domain_byte_valid (domain_byte_valid),
    .domain_byte       (domain_byte),
    .domain_index      (domain_index)
  );

endmodule

// ----- rtl/core/srp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCKS5 request parser checker
// Port-level assertions for the parser core, attached by bind.
// ----------------------------------------------------------------------------
module srp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [7:0] addr_type,
  input logic       domain_byte_valid
);
  import srp_pkg::*;

  // Nothing comes out in the cycle after reset.
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  // Domain characters only appear while a domain request is still open.
  a_domain_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && domain_byte_valid |-> addr_type == TYPE_DOMAIN && status == ST_MORE)
    else $error("domain character outside a domain request");

  a_reject_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_REJECT |->
      addr_type != TYPE_IPV4 && addr_type != TYPE_IPV6 && addr_type != TYPE_DOMAIN)
    else $error("rejected a known address type");

endmodule

bind socks5_request_parser_core srp_checker u_srp_checker (.*);

// ----- verif/tb_socks5_request_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOCKS5 request parser core testbench
// Feeds request bytes with random gaps and random output stalls, predicts
// every result beat from its own parser model and compares them field by
// field in order.
// ----------------------------------------------------------------------------
module tb_socks5_request_parser_core;
  import srp_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  version;
    logic [7:0]  command;
    logic [7:0]  addr_type;
    logic [31:0] ipv4_addr;
    logic [63:0] ipv6_high;
    logic [63:0] ipv6_low;
    logic [15:0] dest_port;
    logic [7:0]  domain_length;
    logic        domain_byte_valid;
    logic [7:0]  domain_byte;
    logic [7:0]  domain_index;
  } parse_result_t;

  typedef enum {
    REQ_IPV4,
    REQ_IPV6,
    REQ_DOMAIN,
    REQ_BADTYPE,
    REQ_NOISE
  } req_kind_t;

  localparam int TARGET_BYTES = 1550;
  localparam int STUCK_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 10;

  class request_scoreboard;
    phase_t      ph;
    logic [2:0]  hdr_cnt;
    logic [7:0]  ver_q;
    logic [7:0]  cmd_q;
    logic [7:0]  type_q;
    logic [4:0]  addr_cnt;
    logic [63:0] addr_word [2];
    logic [7:0]  name_len;
    logic [7:0]  name_cnt;
    logic [15:0] port_word;
    logic [1:0]  port_cnt;
    logic [1:0]  final_st;
    parse_result_t due_results[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph           = PH_HEADER;
      hdr_cnt      = '0;
      ver_q        = '0;
      cmd_q        = '0;
      type_q       = '0;
      addr_cnt     = '0;
      addr_word[0] = '0;
      addr_word[1] = '0;
      name_len     = '0;
      name_cnt     = '0;
      port_word    = '0;
      port_cnt     = '0;
      final_st     = ST_MORE;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Advances the parser by one byte and queues the result it must produce.
    function void note_byte(logic [7:0] b, logic restart_bit);
      parse_result_t r;
      int slot;
      r = '0;
      r.status = ST_MORE;
      if (restart_bit) clear();
      case (ph)
        PH_DONE: begin
          r.status = final_st;
        end
        PH_HEADER: begin
          if (hdr_cnt == 3'd0) ver_q = b;
          else if (hdr_cnt == 3'd1) cmd_q = b;
          else if (hdr_cnt == 3'd3) type_q = b;
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd4) begin
            if (type_q == TYPE_IPV4) begin
              addr_cnt = '0;
              ph = PH_IPV4;
            end else if (type_q == TYPE_IPV6) begin
              addr_cnt = '0;
              ph = PH_IPV6;
            end else if (type_q == TYPE_DOMAIN) begin
              ph = PH_DLEN;
            end else begin
              final_st = ST_REJECT;
              ph = PH_DONE;
              r.status = ST_REJECT;
            end
          end
        end
        PH_IPV4, PH_IPV6: begin
          // The first eight IPv6 bytes go to the upper word; IPv4 and the
          // rest of IPv6 shift into the lower word.
          slot = (ph == PH_IPV6 && addr_cnt < 5'd8) ? 0 : 1;
          addr_word[slot] = {addr_word[slot][55:0], b};
          addr_cnt = addr_cnt + 5'd1;
          if (addr_cnt == ((ph == PH_IPV4) ? 5'd4 : 5'd16)) begin
            port_cnt = '0;
            ph = PH_PORT;
          end
        end
        PH_DLEN: begin
          name_len = b;
          name_cnt = '0;
          if (b == 8'd0) begin
            port_cnt = '0;
            ph = PH_PORT;
          end else begin
            ph = PH_DNAME;
          end
        end
        PH_DNAME: begin
          r.domain_byte_valid = 1'b1;
          r.domain_byte = b;
          r.domain_index = name_cnt;
          name_cnt = name_cnt + 8'd1;
          if (name_cnt == name_len) begin
            port_cnt = '0;
            ph = PH_PORT;
          end
        end
        default: begin
          port_word = {port_word[7:0], b};
          port_cnt = port_cnt + 2'd1;
          if (port_cnt == 2'd2) begin
            final_st = ST_COMPLETE;
            ph = PH_DONE;
            r.status = ST_COMPLETE;
          end
        end
      endcase
      r.version       = ver_q;
      r.command       = cmd_q;
      r.addr_type     = type_q;
      r.ipv4_addr     = (type_q == TYPE_IPV4) ? addr_word[1][31:0] : 32'd0;
      r.ipv6_high     = (type_q == TYPE_IPV6) ? addr_word[0] : 64'd0;
      r.ipv6_low      = (type_q == TYPE_IPV6) ? addr_word[1] : 64'd0;
      r.dest_port     = port_word;
      r.domain_length = name_len;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, actual %0h",
                 $time, got);
        return;
      end
      want = due_results.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("version", 64'(want.version), 64'(got.version));
      compare_field("command", 64'(want.command), 64'(got.command));
      compare_field("addr_type", 64'(want.addr_type), 64'(got.addr_type));
      compare_field("ipv4_addr", 64'(want.ipv4_addr), 64'(got.ipv4_addr));
      compare_field("ipv6_high", want.ipv6_high, got.ipv6_high);
      compare_field("ipv6_low", want.ipv6_low, got.ipv6_low);
      compare_field("dest_port", 64'(want.dest_port), 64'(got.dest_port));
      compare_field("domain_length", 64'(want.domain_length), 64'(got.domain_length));
      compare_field("domain_byte_valid", 64'(want.domain_byte_valid),
                    64'(got.domain_byte_valid));
      compare_field("domain_byte", 64'(want.domain_byte), 64'(got.domain_byte));
      compare_field("domain_index", 64'(want.domain_index), 64'(got.domain_index));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  version;
  logic [7:0]  command;
  logic [7:0]  addr_type;
  logic [31:0] ipv4_addr;
  logic [63:0] ipv6_high;
  logic [63:0] ipv6_low;
  logic [15:0] dest_port;
  logic [7:0]  domain_length;
  logic        domain_byte_valid;
  logic [7:0]  domain_byte;
  logic [7:0]  domain_index;

  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int stuck_cycles = 0;
  request_scoreboard sb;

  socks5_request_parser_core uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .restart           (restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .version           (version),
    .command           (command),
    .addr_type         (addr_type),
    .ipv4_addr         (ipv4_addr),
    .ipv6_high         (ipv6_high),
    .ipv6_low          (ipv6_low),
    .dest_port         (dest_port),
    .domain_length     (domain_length),
    .domain_byte_valid (domain_byte_valid),
    .domain_byte       (domain_byte),
    .domain_index      (domain_index)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Both channels are sampled at the clock edge, the same way the flops see them.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_byte(data_byte, restart);
      end
      if (out_valid && !out_stall) begin
        sb.check_result('{status, version, command, addr_type, ipv4_addr, ipv6_high,
                          ipv6_low, dest_port, domain_length, domain_byte_valid,
                          domain_byte, domain_index});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: a random stall before each result beat.
  initial begin
    int hold;
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic r);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    restart   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Builds one request of the given kind with random content, possibly cut
  // short, and sends it. A negative name_size picks a random domain length.
  task automatic send_request(input req_kind_t kind, input int name_size, output int sent);
    logic [7:0] bytes[$];
    logic [7:0] t;
    logic       r;
    int         n;
    int         i;
    bytes = {};
    if (kind == REQ_NOISE) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h05);
      bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(1, 3)));
      bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
      case (kind)
        REQ_IPV4: begin
          bytes.push_back(TYPE_IPV4);
          for (i = 0; i < 4; i++) bytes.push_back(8'($urandom_range(0, 255)));
        end
        REQ_IPV6: begin
          bytes.push_back(TYPE_IPV6);
          for (i = 0; i < 16; i++) bytes.push_back(8'($urandom_range(0, 255)));
        end
        REQ_DOMAIN: begin
          bytes.push_back(TYPE_DOMAIN);
          if (name_size >= 0) n = name_size;
          else if ($urandom_range(0, 19) == 0) n = $urandom_range(100, 255);
          else n = $urandom_range(0, 12);
          bytes.push_back(8'(n));
          for (i = 0; i < n; i++) bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          do t = 8'($urandom_range(0, 255));
          while (t == TYPE_IPV4 || t == TYPE_IPV6 || t == TYPE_DOMAIN);
          bytes.push_back(t);
        end
      endcase
      if (kind != REQ_BADTYPE) begin
        bytes.push_back(8'($urandom_range(0, 255)));
        bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, bytes.size() - 1);
        while (bytes.size() > n) void'(bytes.pop_back());
      end
    end
    for (i = 0; i < bytes.size(); i++) begin
      if (i == 0) r = ($urandom_range(0, 15) != 0);
      else if (kind == REQ_NOISE) r = 1'($urandom_range(0, 1));
      else r = ($urandom_range(0, 63) == 0);
      send_beat(bytes[i], r);
    end
    sent = bytes.size();
  endtask

  initial begin
    int total;
    int n;
    int pick;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // IPv4 request with extreme address and port bytes.
    send_beat(8'h05, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(TYPE_IPV4, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'hff, 1'b0);
    // Once complete, further bytes are ignored and the status repeats.
    send_beat(8'h00, 1'b0);
    // Unknown address type is rejected on the fourth header byte.
    send_beat(8'hff, 1'b1);
    send_beat(8'hff, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h5a, 1'b0);
    // A zero domain length skips straight to the port.
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(TYPE_DOMAIN, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);

    total = 0;
    send_request(REQ_DOMAIN, 255, n);
    total += n;
    while (total < TARGET_BYTES) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: send_request(REQ_IPV4, -1, n);
        3, 4, 5: send_request(REQ_DOMAIN, -1, n);
        6, 7:    send_request(REQ_IPV6, -1, n);
        8:       send_request(REQ_BADTYPE, -1, n);
        default: send_request(REQ_NOISE, -1, n);
      endcase
      total += n;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    in_valid <= 1'b0;
    in_burst = 1'b0;
    out_burst = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
